// ===== sv/spc_alu_pkg.sv =====
// Shared types and constants for the SPC700-style ALU block.
// Holds the operation codes and the status-flag and result record types.
// No dependencies.
package spc_alu_pkg;

    localparam int unsigned OP_W   = 5;
    localparam int unsigned DATA_W = 16;
    localparam int unsigned BYTE_W = 8;

    typedef enum logic [OP_W-1:0] {
        OP_ADC  = 5'd0,
        OP_ADDW = 5'd1,
        OP_AND  = 5'd2,
        OP_CMP  = 5'd3,
        OP_CMPW = 5'd4,
        OP_EOR  = 5'd5,
        OP_OR   = 5'd6,
        OP_SBC  = 5'd7,
        OP_SUBW = 5'd8,
        OP_INC  = 5'd9,
        OP_INCW = 5'd10,
        OP_DEC  = 5'd11,
        OP_DECW = 5'd12,
        OP_ASL  = 5'd13,
        OP_LSR  = 5'd14,
        OP_ROL  = 5'd15,
        OP_ROR  = 5'd16
    } op_t;

    typedef struct packed {
        logic n;
        logic v;
        logic h;
        logic z;
        logic c;
    } flags_t;

    typedef struct packed {
        logic [DATA_W-1:0] result;
        flags_t            flags;
    } alu_out_t;

endpackage

// ===== sv/spc_alu.sv =====
// Combinational datapath of the SPC700-style ALU: one shared 17-bit adder
// for all add, subtract, compare, increment and decrement forms, plus logic and shifts.
// Depends on spc_alu_pkg.
module spc_alu
    import spc_alu_pkg::*;
(
    input  op_t                op,
    input  logic [DATA_W-1:0]  operand_a,
    input  logic [DATA_W-1:0]  operand_b,
    input  flags_t             flags_in,
    output alu_out_t           alu_out
);

    logic [DATA_W-1:0] add_x;
    logic [DATA_W-1:0] add_y;
    logic              add_cin;
    logic [DATA_W:0]   sum;
    logic [DATA_W-1:0] carry_vec;
    logic [DATA_W-1:0] ovf_vec;
    logic [BYTE_W-1:0] a8;
    logic [BYTE_W-1:0] b8;
    logic [BYTE_W-1:0] r8;
    logic [DATA_W-1:0] r16;

    assign a8 = operand_a[BYTE_W-1:0];
    assign b8 = operand_b[BYTE_W-1:0];

    // Operand selection for the shared adder. Subtraction adds the inverted
    // second operand, so the carry out is the no-borrow flag.
    always_comb begin
        add_x   = {8'h00, a8};
        add_y   = '0;
        add_cin = 1'b0;
        unique case (op)
            OP_ADC: begin
                add_y   = {8'h00, b8};
                add_cin = flags_in.c;
            end
            OP_SBC: begin
                add_y   = {8'h00, ~b8};
                add_cin = flags_in.c;
            end
            OP_CMP: begin
                add_y   = {8'h00, ~b8};
                add_cin = 1'b1;
            end
            OP_ADDW: begin
                add_x = operand_a;
                add_y = operand_b;
            end
            OP_SUBW, OP_CMPW: begin
                add_x   = operand_a;
                add_y   = ~operand_b;
                add_cin = 1'b1;
            end
            OP_INC: begin
                add_cin = 1'b1;
            end
            OP_DEC: begin
                add_y = 16'h00ff;
            end
            OP_INCW: begin
                add_x   = operand_a;
                add_cin = 1'b1;
            end
            OP_DECW: begin
                add_x = operand_a;
                add_y = 16'hffff;
            end
            default: begin
                add_x = {8'h00, a8};
            end
        endcase
    end

    assign sum       = {1'b0, add_x} + {1'b0, add_y} + {{DATA_W{1'b0}}, add_cin};
    assign carry_vec = add_x ^ add_y ^ sum[DATA_W-1:0];
    assign ovf_vec   = ~(add_x ^ add_y) & (add_y ^ sum[DATA_W-1:0]);
    assign r8        = sum[BYTE_W-1:0];
    assign r16       = sum[DATA_W-1:0];

    always_comb begin
        alu_out.result = '0;
        alu_out.flags  = flags_in;
        unique case (op)
            OP_ADC, OP_SBC: begin
                alu_out.result  = {8'h00, r8};
                alu_out.flags.n = r8[7];
                alu_out.flags.z = (r8 == 8'h00);
                alu_out.flags.v = ovf_vec[7];
                alu_out.flags.h = carry_vec[4];
                alu_out.flags.c = sum[8];
            end
            OP_ADDW, OP_SUBW: begin
                alu_out.result  = r16;
                alu_out.flags.n = r16[15];
                alu_out.flags.z = (r16 == 16'h0000);
                alu_out.flags.v = ovf_vec[15];
                alu_out.flags.h = carry_vec[12];
                alu_out.flags.c = sum[16];
            end
            OP_CMP: begin
                alu_out.result  = {8'h00, a8};
                alu_out.flags.n = r8[7];
                alu_out.flags.z = (r8 == 8'h00);
                alu_out.flags.c = sum[8];
            end
            OP_CMPW: begin
                alu_out.result  = operand_a;
                alu_out.flags.n = r16[15];
                alu_out.flags.z = (r16 == 16'h0000);
                alu_out.flags.c = sum[16];
            end
            OP_INC, OP_DEC: begin
                alu_out.result  = {8'h00, r8};
                alu_out.flags.n = r8[7];
                alu_out.flags.z = (r8 == 8'h00);
            end
            OP_INCW, OP_DECW: begin
                alu_out.result  = r16;
                alu_out.flags.n = r16[15];
                alu_out.flags.z = (r16 == 16'h0000);
            end
            OP_AND: begin
                alu_out.result  = {8'h00, a8 & b8};
                alu_out.flags.n = alu_out.result[7];
                alu_out.flags.z = ((a8 & b8) == 8'h00);
            end
            OP_OR: begin
                alu_out.result  = {8'h00, a8 | b8};
                alu_out.flags.n = alu_out.result[7];
                alu_out.flags.z = ((a8 | b8) == 8'h00);
            end
            OP_EOR: begin
                alu_out.result  = {8'h00, a8 ^ b8};
                alu_out.flags.n = alu_out.result[7];
                alu_out.flags.z = ((a8 ^ b8) == 8'h00);
            end
            OP_ASL, OP_ROL: begin
                alu_out.result  = {8'h00, a8[6:0], (op == OP_ROL) & flags_in.c};
                alu_out.flags.n = a8[6];
                alu_out.flags.z = (alu_out.result[7:0] == 8'h00);
                alu_out.flags.c = a8[7];
            end
            OP_LSR, OP_ROR: begin
                alu_out.result  = {8'h00, (op == OP_ROR) & flags_in.c, a8[7:1]};
                alu_out.flags.n = alu_out.result[7];
                alu_out.flags.z = (alu_out.result[7:0] == 8'h00);
                alu_out.flags.c = a8[0];
            end
            default: begin
                // Unassigned codes give zero and leave the flags alone.
                alu_out.result = '0;
            end
        endcase
    end

endmodule

// ===== sv/spc700_alu_with_flags.sv =====
// Top level of the SPC700-style ALU: input register, datapath, result register
// and the kept N V H Z C status register. Depends on spc_alu_pkg and spc_alu.
//
// The block takes one operation per clock cycle while the output is not held
// back by m_tready; each beat passes through the input register and then the
// result register. The status flags live in a single register that is written in
// the same cycle the result register loads, so every operation sees the flags
// left by the one before it with no stall. Flags come out of reset cleared, and
// each result beat carries the full flag set as it stands after that operation.
// Codes 17 to 31 return zero and leave the flags unchanged.
module spc700_alu_with_flags
    import spc_alu_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [15:0] operand_a, [31:16] operand_b
    input  logic [4:0]  s_tuser,   // [4:0] operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // [15:0] result, [16] flag_negative,
                                   // [17] flag_overflow, [18] flag_half_carry,
                                   // [19] flag_zero, [20] flag_carry, [23:21] zero
);

    logic              in_valid_reg;
    op_t               op_reg;
    logic [DATA_W-1:0] a_reg;
    logic [DATA_W-1:0] b_reg;
    logic              m_valid_reg;
    alu_out_t          res_reg;
    alu_out_t          res_next;
    flags_t            flags_reg;
    logic              out_free;
    logic              advance;
    logic              op_undef;
    logic              op_byte;
    logic              op_compare;

    spc_alu u_alu (
        .op        (op_reg),
        .operand_a (a_reg),
        .operand_b (b_reg),
        .flags_in  (flags_reg),
        .alu_out   (res_next)
    );

    assign out_free = !m_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            flags_reg    <= '0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (out_free) begin
                m_valid_reg <= in_valid_reg;
            end
            if (advance) begin
                flags_reg <= res_next.flags;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            op_reg <= op_t'(s_tuser);
            a_reg  <= s_tdata[15:0];
            b_reg  <= s_tdata[31:16];
        end
        if (advance) begin
            res_reg <= res_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'b000, res_reg.flags.c, res_reg.flags.z, res_reg.flags.h,
                       res_reg.flags.v, res_reg.flags.n, res_reg.result};

    // Decode helpers used by the checks below.
    assign op_undef   = (op_reg > OP_ROR);
    assign op_compare = (op_reg == OP_CMP) || (op_reg == OP_CMPW);
    assign op_byte    = !op_undef && (op_reg != OP_ADDW) && (op_reg != OP_SUBW)
                        && (op_reg != OP_CMPW) && (op_reg != OP_INCW)
                        && (op_reg != OP_DECW);

    // The kept flags always match the flags of the newest result beat.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (flags_reg == res_reg.flags))
        else $error("status register out of step with result register");

    // An unassigned code must not disturb the flags.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && op_undef) |=> $stable(flags_reg))
        else $error("flags changed on unassigned operation");

    // Byte operations return a clear high byte.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && op_byte) |=> (res_reg.result[15:8] == 8'h00))
        else $error("byte operation left a nonzero high byte");

    // Outside compares, Z reflects the delivered result.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && !op_undef && !op_compare)
            |=> (res_reg.flags.z == (res_reg.result == 16'h0000)))
        else $error("zero flag disagrees with result");

endmodule
